[hdl/qau_pkg.sv]
// ----------------------------------------------------------------------------
// qau_pkg
// Shared operation codes, status codes and the Hamilton product term table
// for the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

  // operation codes carried with each item
  typedef enum logic [3:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_SCALE,
    OP_DIVSCALAR,
    OP_SCALAR_OVER_A,
    OP_NEGATE,
    OP_INVERT,
    OP_NORMALIZE,
    OP_NORMSQ,
    OP_NORM,
    OP_EQUAL
  } op_t;

  // result status
  typedef enum logic [1:0] {
    ST_OK,
    ST_SAT,
    ST_DIV0
  } status_t;

  // index into the first operand for term t of component i
  // (the second operand index is always t)
  localparam logic [1:0] HAM_A [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };

  // bit t set: term t of component i is subtracted
  localparam logic [3:0] HAM_SUB [4] = '{4'b1110, 4'b0100, 4'b1000, 4'b0010};

endpackage

[hdl/qau_delay.sv]
// ----------------------------------------------------------------------------
// qau_delay
// Fixed-depth register line that keeps item side data aligned with the
// arithmetic pipelines.
// ----------------------------------------------------------------------------
module qau_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] line [DEPTH];

  // shift the side data one stage per cycle
  for (genvar s = 0; s < DEPTH; s++) begin : g_line
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        line[s] <= din;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        line[s] <= line[s-1];
      end
    end
  end

  assign dout = line[DEPTH-1];

endmodule

[hdl/qau_sqrt.sv]
// ----------------------------------------------------------------------------
// qau_sqrt
// Pipelined integer square root, one root bit per stage, working on the
// remainder so that no multiplier is needed.
// ----------------------------------------------------------------------------
module qau_sqrt #(
  parameter int CW = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [2*CW:0]   in_s,
  output logic            out_valid,
  output logic [CW:0]     out_root
);

  localparam int SW = 2 * CW + 1;
  localparam int RW = CW + 1;
  localparam int TW = 2 * CW + 3;

  logic [SW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic          vld_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [SW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic          vld_in;
    logic [TW-1:0] trial;
    logic          take;

    if (k == 0) begin : g_in
      assign rem_in  = in_s;
      assign root_in = '0;
      assign vld_in  = in_valid;
    end else begin : g_prev
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // (r + 2^B)^2 - r^2 against what is left of the radicand
    assign trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
    assign take  = trial <= TW'(rem_in);

    always_ff @(posedge clk) begin
      vld_q[k]  <= rst ? 1'b0 : vld_in;
      rem_q[k]  <= take ? SW'(TW'(rem_in) - trial) : rem_in;
      root_q[k] <= take ? (root_in | (RW'(1) << B)) : root_in;
    end
  end

  assign out_valid = vld_q[RW-1];
  assign out_root  = root_q[RW-1];

endmodule

[hdl/qau_div.sv]
// ----------------------------------------------------------------------------
// qau_div
// Four-lane pipelined restoring divider sharing one divisor. The first stage
// flags quotients that do not fit COMPONENT_WIDTH bits, then one quotient bit
// is produced per stage.
// ----------------------------------------------------------------------------
module qau_div #(
  parameter int CW = 32,
  parameter int FB = 28
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [3:0][CW+2*FB-1:0]       in_num,
  input  logic [2*CW:0]                 in_den,
  output logic                          out_valid,
  output logic [3:0][CW-1:0]            out_quo,
  output logic [3:0]                    out_ovf
);

  localparam int NW   = CW + 2 * FB;
  localparam int DW   = 2 * CW + 1;
  localparam int HW   = 2 * FB;
  localparam int CMPW = (HW > DW) ? HW : DW;

  logic [3:0][DW-1:0] rem_q [CW+1];
  logic [3:0][CW-1:0] low_q [CW+1];
  logic [3:0][CW-1:0] quo_q [CW+1];
  logic [3:0]         ovf_q [CW+1];
  logic [DW-1:0]      den_q [CW+1];
  logic               vld_q [CW+1];

  logic [3:0][CMPW-1:0] hi_ext;
  logic [3:0]           ovf_in;

  // overflow check: quotient >= 2^CW when the upper numerator part >= divisor
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      hi_ext[l] = CMPW'(in_num[l][NW-1:CW]);
      ovf_in[l] = hi_ext[l] >= CMPW'(in_den);
    end
  end

  always_ff @(posedge clk) begin
    vld_q[0] <= rst ? 1'b0 : in_valid;
    den_q[0] <= in_den;
    ovf_q[0] <= ovf_in;
    for (int l = 0; l < 4; l++) begin
      rem_q[0][l] <= hi_ext[l][DW-1:0];
      low_q[0][l] <= in_num[l][CW-1:0];
      quo_q[0][l] <= '0;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= CW; k++) begin : g_step
    logic [3:0][DW:0]   trial;
    logic [3:0][DW:0]   diff;
    logic [3:0]         ge;

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        trial[l] = {rem_q[k-1][l], low_q[k-1][l][CW-1]};
        diff[l]  = trial[l] - {1'b0, den_q[k-1]};
        ge[l]    = trial[l] >= {1'b0, den_q[k-1]};
      end
    end

    always_ff @(posedge clk) begin
      vld_q[k] <= rst ? 1'b0 : vld_q[k-1];
      den_q[k] <= den_q[k-1];
      ovf_q[k] <= ovf_q[k-1];
      for (int l = 0; l < 4; l++) begin
        rem_q[k][l] <= ge[l] ? diff[l][DW-1:0] : trial[l][DW-1:0];
        low_q[k][l] <= {low_q[k-1][l][CW-2:0], 1'b0};
        quo_q[k][l] <= {quo_q[k-1][l][CW-2:0], ge[l]};
      end
    end
  end

  assign out_valid = vld_q[CW];
  assign out_quo   = quo_q[CW];
  assign out_ovf   = ovf_q[CW];

endmodule

[hdl/qau_ham.sv]
// ----------------------------------------------------------------------------
// qau_ham
// Three-stage Hamilton product: sixteen products, signed term sums, then
// round to nearest (ties away from zero) and saturate per component.
// ----------------------------------------------------------------------------
module qau_ham
  import qau_pkg::*;
#(
  parameter int CW = 32,
  parameter int FB = 28
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [3:0][CW-1:0]   x,
  input  logic [3:0][CW-1:0]   y,
  output logic                 out_valid,
  output logic [3:0][CW-1:0]   res,
  output logic                 sat
);

  localparam int MW = 2 * CW;
  localparam int PW = 2 * CW + 2;

  logic               vld1, vld2, vld3;
  logic signed [MW-1:0] prod [4][4];
  logic signed [PW-1:0] acc  [4];
  logic signed [PW-1:0] acc_next [4];
  logic [PW-1:0]      mag  [4];
  logic [PW:0]        rnd  [4];
  logic [PW:0]        lim  [4];
  logic [PW:0]        m    [4];
  logic [3:0]         sat_c;
  logic [3:0][CW-1:0] res_c;

  // products
  always_ff @(posedge clk) begin
    vld1 <= rst ? 1'b0 : in_valid;
    for (int i = 0; i < 4; i++) begin
      for (int t = 0; t < 4; t++) begin
        prod[i][t] <= MW'($signed(x[HAM_A[i][t]]) * $signed(y[t]));
      end
    end
  end

  // signed term sums
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc_next[i] = '0;
      for (int t = 0; t < 4; t++) begin
        if (HAM_SUB[i][t]) begin
          acc_next[i] = acc_next[i] - PW'(prod[i][t]);
        end else begin
          acc_next[i] = acc_next[i] + PW'(prod[i][t]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    vld2 <= rst ? 1'b0 : vld1;
    acc  <= acc_next;
  end

  // round, shift and clamp on the magnitude
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i]   = acc[i][PW-1] ? PW'(-acc[i]) : PW'(acc[i]);
      rnd[i]   = ({1'b0, mag[i]} + ((PW+1)'(1) << (FB - 1))) >> FB;
      lim[i]   = acc[i][PW-1] ? ((PW+1)'(1) << (CW - 1))
                              : (((PW+1)'(1) << (CW - 1)) - (PW+1)'(1));
      sat_c[i] = rnd[i] > lim[i];
      m[i]     = sat_c[i] ? lim[i] : rnd[i];
      res_c[i] = acc[i][PW-1] ? CW'(-m[i][CW-1:0]) : m[i][CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    vld3 <= rst ? 1'b0 : vld2;
    res  <= res_c;
    sat  <= |sat_c;
  end

  assign out_valid = vld3;

endmodule

[hdl/quaternion_arithmetic_unit.sv]
// Pipeline: every item passes through the square root stages (one per root bit)
// and then the divider stages (one per quotient bit) on its way to done.
// Throughput: one item per cycle; busy stays low and done is a one-cycle strobe.
// Reset: rst clears every valid bit in the pipeline; items in flight are lost.
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Fixed point quaternion ALU: add, sub, negate, Hamilton product, quotient,
// scaling, inverse, normalizing, norm, norm squared, equality; fully pipelined.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit
  import qau_pkg::*;
#(
  parameter int COMPONENT_WIDTH = 32,
  parameter int FRACTION_BITS   = 28
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [3:0]                        operation,
  input  logic signed [COMPONENT_WIDTH-1:0] a_w,
  input  logic signed [COMPONENT_WIDTH-1:0] a_x,
  input  logic signed [COMPONENT_WIDTH-1:0] a_y,
  input  logic signed [COMPONENT_WIDTH-1:0] a_z,
  input  logic signed [COMPONENT_WIDTH-1:0] b_w,
  input  logic signed [COMPONENT_WIDTH-1:0] b_x,
  input  logic signed [COMPONENT_WIDTH-1:0] b_y,
  input  logic signed [COMPONENT_WIDTH-1:0] b_z,
  input  logic signed [COMPONENT_WIDTH-1:0] scalar_in,
  output logic                              done,
  output logic signed [COMPONENT_WIDTH-1:0] res_w,
  output logic signed [COMPONENT_WIDTH-1:0] res_x,
  output logic signed [COMPONENT_WIDTH-1:0] res_y,
  output logic signed [COMPONENT_WIDTH-1:0] res_z,
  output logic signed [COMPONENT_WIDTH+7:0] scalar_out,
  output logic                              is_equal,
  output logic [1:0]                        status
);

  localparam int CW  = COMPONENT_WIDTH;
  localparam int FB  = FRACTION_BITS;
  localparam int SW2 = 2 * CW + 1;
  localparam int RW  = CW + 1;
  localparam int NW  = CW + 2 * FB;
  localparam int SCW = CW + 8;
  localparam int TW  = 2 * CW + 2;

  typedef struct packed {
    op_t                op;
    logic [3:0][CW-1:0] a;
    logic [3:0][CW-1:0] b;
    logic [CW-1:0]      k;
    logic [SW2-1:0]     s;
  } side1_t;

  typedef struct packed {
    side1_t        base;
    logic [RW-1:0] root;
  } side2_t;

  typedef struct packed {
    side2_t             base;
    logic [3:0][CW-1:0] qv;
    logic               qsat;
  } side3_t;

  // input, squares and sum of squares stages
  logic               v0, v1, v2;
  op_t                op0, op1, op2;
  logic [3:0][CW-1:0] a0, b0, a1, b1, a2, b2;
  logic [CW-1:0]      k0, k1, k2;
  logic [3:0][2*CW-1:0] sq1;
  logic [3:0][CW-1:0] qsel0;
  logic [SW2-1:0]     s2;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    v0  <= rst ? 1'b0 : (start && !busy);
    op0 <= op_t'(operation);
    a0  <= {a_z, a_y, a_x, a_w};
    b0  <= {b_z, b_y, b_x, b_w};
    k0  <= scalar_in;
  end

  // the divide operation needs the norm of b, everything else that of a
  assign qsel0 = (op0 == OP_DIV) ? b0 : a0;

  always_ff @(posedge clk) begin
    v1  <= rst ? 1'b0 : v0;
    op1 <= op0;
    a1  <= a0;
    b1  <= b0;
    k1  <= k0;
    for (int i = 0; i < 4; i++) begin
      sq1[i] <= (2*CW)'($signed(qsel0[i]) * $signed(qsel0[i]));
    end
  end

  always_ff @(posedge clk) begin
    v2  <= rst ? 1'b0 : v1;
    op2 <= op1;
    a2  <= a1;
    b2  <= b1;
    k2  <= k1;
    s2  <= SW2'(sq1[0]) + SW2'(sq1[1]) + SW2'(sq1[2]) + SW2'(sq1[3]);
  end

  // square root of the sum of squares
  side1_t        side1_in, d1;
  logic          v3;
  logic [RW-1:0] root3;

  assign side1_in = '{op: op2, a: a2, b: b2, k: k2, s: s2};

  qau_sqrt #(.CW(CW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v2),
    .in_s     (s2),
    .out_valid(v3),
    .out_root (root3)
  );

  qau_delay #(.W($bits(side1_t)), .DEPTH(RW)) u_dly1 (
    .clk (clk),
    .din (side1_in),
    .dout(d1)
  );

  // divider operand selection
  logic [3:0][NW-1:0] num3;
  logic [SW2-1:0]     den3;
  logic [3:0][CW-1:0] qmag3, amag3;
  logic [CW-1:0]      kmag3;
  logic [CW-1:0]      qcomp;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      qcomp    = (d1.op == OP_DIV) ? d1.b[l] : d1.a[l];
      qmag3[l] = qcomp[CW-1] ? -qcomp : qcomp;
      amag3[l] = d1.a[l][CW-1] ? -d1.a[l] : d1.a[l];
    end
    kmag3 = d1.k[CW-1] ? -d1.k : d1.k;
    num3  = '0;
    den3  = d1.s;
    unique case (d1.op)
      OP_DIV, OP_SCALAR_OVER_A, OP_INVERT: begin
        for (int l = 0; l < 4; l++) num3[l] = NW'(qmag3[l]) << (2 * FB);
      end
      OP_DIVSCALAR: begin
        for (int l = 0; l < 4; l++) num3[l] = NW'(amag3[l]) << FB;
        den3 = SW2'(kmag3);
      end
      OP_NORMALIZE: begin
        for (int l = 0; l < 4; l++) num3[l] = NW'(amag3[l]) << FB;
        den3 = SW2'(root3);
      end
      default: ;
    endcase
  end

  side2_t             side2_in, d2;
  logic               v4;
  logic [3:0][CW-1:0] quo4;
  logic [3:0]         ovf4;

  assign side2_in = '{base: d1, root: root3};

  qau_div #(.CW(CW), .FB(FB)) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v3),
    .in_num   (num3),
    .in_den   (den3),
    .out_valid(v4),
    .out_quo  (quo4),
    .out_ovf  (ovf4)
  );

  qau_delay #(.W($bits(side2_t)), .DEPTH(CW + 1)) u_dly2 (
    .clk (clk),
    .din (side2_in),
    .dout(d2)
  );

  // quotient sign and saturation
  logic [3:0]         qneg4, qs4;
  logic [3:0][CW-1:0] qlim4, qm4, qv4;
  logic               qsat4;
  logic [CW-1:0]      qsrc;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      qsrc = (d2.base.op == OP_DIV) ? d2.base.b[l] : d2.base.a[l];
      unique case (d2.base.op)
        OP_DIVSCALAR: qneg4[l] = d2.base.a[l][CW-1] ^ d2.base.k[CW-1];
        OP_NORMALIZE: qneg4[l] = d2.base.a[l][CW-1];
        default:      qneg4[l] = qsrc[CW-1] ^ (l != 0);
      endcase
      qlim4[l] = qneg4[l] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      qs4[l]   = ovf4[l] || (quo4[l] > qlim4[l]);
      qm4[l]   = qs4[l] ? qlim4[l] : quo4[l];
      qv4[l]   = qneg4[l] ? -qm4[l] : qm4[l];
    end
    unique case (d2.base.op)
      OP_DIV, OP_SCALAR_OVER_A, OP_INVERT, OP_DIVSCALAR, OP_NORMALIZE: qsat4 = |qs4;
      default: qsat4 = 1'b0;
    endcase
  end

  logic               v5;
  side2_t             r5;
  logic [3:0][CW-1:0] qv5;
  logic               qsat5;

  always_ff @(posedge clk) begin
    v5    <= rst ? 1'b0 : v4;
    r5    <= d2;
    qv5   <= qv4;
    qsat5 <= qsat4;
  end

  // product operand selection: scaling uses k as the real part only
  logic [3:0][CW-1:0] hx, hy;

  always_comb begin
    hx = r5.base.a;
    hy = '0;
    unique case (r5.base.op)
      OP_MUL:           hy = r5.base.b;
      OP_DIV:           hy = qv5;
      OP_SCALE:         hy[0] = r5.base.k;
      OP_SCALAR_OVER_A: begin
        hx    = qv5;
        hy[0] = r5.base.k;
      end
      default: ;
    endcase
  end

  side3_t             side3_in, d3;
  logic               v6;
  logic [3:0][CW-1:0] hres6;
  logic               hsat6;

  assign side3_in = '{base: r5, qv: qv5, qsat: qsat5};

  qau_ham #(.CW(CW), .FB(FB)) u_ham (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v5),
    .x        (hx),
    .y        (hy),
    .out_valid(v6),
    .res      (hres6),
    .sat      (hsat6)
  );

  qau_delay #(.W($bits(side3_t)), .DEPTH(3)) u_dly3 (
    .clk (clk),
    .din (side3_in),
    .dout(d3)
  );

  // final result selection
  op_t                fop;
  logic [3:0][CW-1:0] fa, fb;
  logic [3:0][CW:0]   addsum;
  logic [TW-1:0]      nsq;
  logic [TW-1:0]      nsq_lim;
  logic [3:0][CW-1:0] res_c;
  logic [SCW-1:0]     sc_c;
  logic               eq_c, sat_c, dz_c;
  logic [3:0]         csat;
  logic               s_zero;

  assign fop     = d3.base.base.op;
  assign fa      = d3.base.base.a;
  assign fb      = d3.base.base.b;
  assign s_zero  = (d3.base.base.s == '0);
  assign nsq     = (TW'(d3.base.base.s) + (TW'(1) << (FB - 1))) >> FB;
  assign nsq_lim = TW'({1'b0, {(SCW-1){1'b1}}});

  always_comb begin
    res_c = '0;
    sc_c  = '0;
    eq_c  = 1'b0;
    sat_c = 1'b0;
    dz_c  = 1'b0;
    csat  = '0;
    for (int l = 0; l < 4; l++) begin
      addsum[l] = (fop == OP_SUB) ? ({fa[l][CW-1], fa[l]} - {fb[l][CW-1], fb[l]})
                                  : ({fa[l][CW-1], fa[l]} + {fb[l][CW-1], fb[l]});
    end
    unique case (fop)
      OP_ADD, OP_SUB: begin
        for (int l = 0; l < 4; l++) begin
          csat[l] = addsum[l][CW] != addsum[l][CW-1];
          if (csat[l]) begin
            res_c[l] = addsum[l][CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
          end else begin
            res_c[l] = addsum[l][CW-1:0];
          end
        end
        sat_c = |csat;
      end
      OP_MUL, OP_SCALE: begin
        res_c = hres6;
        sat_c = hsat6;
      end
      OP_DIV, OP_SCALAR_OVER_A: begin
        dz_c  = s_zero;
        res_c = hres6;
        sat_c = hsat6 | d3.qsat;
      end
      OP_DIVSCALAR: begin
        dz_c  = (d3.base.base.k == '0);
        res_c = d3.qv;
        sat_c = d3.qsat;
      end
      OP_INVERT, OP_NORMALIZE: begin
        dz_c  = s_zero;
        res_c = d3.qv;
        sat_c = d3.qsat;
      end
      OP_NEGATE: begin
        for (int l = 0; l < 4; l++) begin
          csat[l]  = (fa[l] == {1'b1, {(CW-1){1'b0}}});
          res_c[l] = csat[l] ? {1'b0, {(CW-1){1'b1}}} : -fa[l];
        end
        sat_c = |csat;
      end
      OP_NORMSQ: begin
        sat_c = nsq > nsq_lim;
        sc_c  = sat_c ? nsq_lim[SCW-1:0] : nsq[SCW-1:0];
      end
      OP_NORM: sc_c = SCW'(d3.base.root);
      OP_EQUAL: eq_c = (fa == fb);
      default: ;
    endcase
  end

  // output register
  logic [3:0][CW-1:0] res_q;
  logic [SCW-1:0]     sc_q;
  logic               eq_q;
  status_t            st_q;

  always_ff @(posedge clk) begin
    done <= rst ? 1'b0 : v6;
    if (dz_c) begin
      res_q <= '0;
      sc_q  <= '0;
      eq_q  <= 1'b0;
      st_q  <= ST_DIV0;
    end else begin
      res_q <= res_c;
      sc_q  <= sc_c;
      eq_q  <= eq_c;
      st_q  <= sat_c ? ST_SAT : ST_OK;
    end
  end

  assign res_w      = res_q[0];
  assign res_x      = res_q[1];
  assign res_y      = res_q[2];
  assign res_z      = res_q[3];
  assign scalar_out = sc_q;
  assign is_equal   = eq_q;
  assign status     = st_q;

endmodule
